[design/hsc_pkg.sv]
// ----------------------------------------------------------------------------
// hsc_pkg: shared types and constants for the host scope classifier
// Character codes, class codes and the verdict structure passed from the
// parser to the top level.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned LenW     = 4;
  localparam int unsigned OctetW   = 9;
  localparam int unsigned AddrW    = 32;

  localparam logic [LenW-1:0]   LenMax       = 4'd15;
  localparam logic [LenW-1:0]   LenLocalhost = 4'd9;
  localparam logic [LenW-1:0]   LenLoop6     = 4'd3;
  localparam logic [LenW-1:0]   LenFcfd      = 4'd2;
  localparam logic [LenW-1:0]   LenLinkLocal = 4'd5;

  localparam logic [OctetW-1:0] OctetSat     = 9'd256;
  localparam logic [OctetW-1:0] OctetMax     = 9'd255;

  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5a;
  localparam logic [CharW-1:0] ChCaseBit = 8'h20;
  localparam logic [CharW-1:0] ChDigit0 = 8'h30;
  localparam logic [CharW-1:0] ChDigit9 = 8'h39;
  localparam logic [CharW-1:0] ChDot    = 8'h2e;
  localparam logic [CharW-1:0] ChColon  = 8'h3a;
  localparam logic [CharW-1:0] ChF      = 8'h66;
  localparam logic [CharW-1:0] ChC      = 8'h63;
  localparam logic [CharW-1:0] ChD      = 8'h64;

  localparam logic [7:0] Oct10  = 8'd10;
  localparam logic [7:0] Oct127 = 8'd127;
  localparam logic [7:0] Oct169 = 8'd169;
  localparam logic [7:0] Oct254 = 8'd254;
  localparam logic [7:0] Oct172 = 8'd172;
  localparam logic [7:0] Oct16  = 8'd16;
  localparam logic [7:0] Oct31  = 8'd31;
  localparam logic [7:0] Oct192 = 8'd192;
  localparam logic [7:0] Oct168 = 8'd168;

  typedef enum logic [2:0] {
    CLS_NONE      = 3'd0,
    CLS_LOCALHOST = 3'd1,
    CLS_PRIV4     = 3'd2,
    CLS_LOOP6     = 3'd3,
    CLS_LOCAL6    = 3'd4
  } class_e;

  typedef struct packed {
    logic             is_local;
    class_e           host_class;
    logic             ipv4_valid;
    logic [AddrW-1:0] ipv4_address;
  } verdict_t;

  // expected byte of "localhost" at a given position
  function automatic logic [CharW-1:0] localhost_char(input logic [LenW-1:0] pos);
    logic [CharW-1:0] ch;
    ch = 8'h00;
    unique case (pos)
      4'd0:    ch = 8'h6c; // l
      4'd1:    ch = 8'h6f; // o
      4'd2:    ch = 8'h63; // c
      4'd3:    ch = 8'h61; // a
      4'd4:    ch = 8'h6c; // l
      4'd5:    ch = 8'h68; // h
      4'd6:    ch = 8'h6f; // o
      4'd7:    ch = 8'h73; // s
      4'd8:    ch = 8'h74; // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // expected byte of "::1"
  function automatic logic [CharW-1:0] loop6_char(input logic [LenW-1:0] pos);
    logic [CharW-1:0] ch;
    ch = 8'h00;
    unique case (pos)
      4'd0:    ch = ChColon;
      4'd1:    ch = ChColon;
      4'd2:    ch = 8'h31; // 1
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // expected byte of "fe80:"
  function automatic logic [CharW-1:0] linklocal_char(input logic [LenW-1:0] pos);
    logic [CharW-1:0] ch;
    ch = 8'h00;
    unique case (pos)
      4'd0:    ch = ChF;
      4'd1:    ch = 8'h65; // e
      4'd2:    ch = 8'h38; // 8
      4'd3:    ch = ChDigit0;
      4'd4:    ch = ChColon;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[design/hsc_parser.sv]
// ----------------------------------------------------------------------------
// hsc_parser: running host name state and verdict logic
// Folds case, tracks name matches and the dotted-quad parse, and forms the
// verdict for the item that ends a host. State returns to reset after it.
// ----------------------------------------------------------------------------
module hsc_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  logic [hsc_pkg::CharW-1:0]   char_i,
  input  logic                        last_i,
  output hsc_pkg::verdict_t           verdict_o
);

  logic [hsc_pkg::LenW-1:0]   len_q, len_d;
  logic                       lh_q, lh_d;
  logic                       lp6_q, lp6_d;
  logic                       fcfd_q, fcfd_d;
  logic                       ll6_q, ll6_d;
  logic                       colon_q, colon_d;
  logic [hsc_pkg::OctetW-1:0] oct_q, oct_d;
  logic [1:0]                 idx_q, idx_d;
  logic                       nonempty_q, nonempty_d;
  logic                       failed_q, failed_d;
  logic [hsc_pkg::AddrW-1:0]  addr_q, addr_d;

  logic [hsc_pkg::CharW-1:0]  ch;
  logic                       is_digit;
  logic [12:0]                oct_acc;
  logic                       v4_ok;
  logic [hsc_pkg::AddrW-1:0]  addr_full;
  logic [7:0]                 oa, ob;
  hsc_pkg::class_e            cls;

  always_comb begin
    ch = char_i;
    if (char_i >= hsc_pkg::ChUpperA && char_i <= hsc_pkg::ChUpperZ) begin
      ch = char_i | hsc_pkg::ChCaseBit;
    end
    is_digit = (ch >= hsc_pkg::ChDigit0) && (ch <= hsc_pkg::ChDigit9);
    oct_acc  = ({4'd0, oct_q} * 13'd10) + {5'd0, ch - hsc_pkg::ChDigit0};

    len_d   = (len_q < hsc_pkg::LenMax) ? len_q + 4'd1 : len_q;
    lh_d    = lh_q && (len_q < hsc_pkg::LenLocalhost) &&
              (ch == hsc_pkg::localhost_char(len_q));
    lp6_d   = lp6_q && (len_q < hsc_pkg::LenLoop6) &&
              (ch == hsc_pkg::loop6_char(len_q));
    fcfd_d  = fcfd_q;
    if (len_q == 4'd0 && ch != hsc_pkg::ChF) begin
      fcfd_d = 1'b0;
    end
    if (len_q == 4'd1 && ch != hsc_pkg::ChC && ch != hsc_pkg::ChD) begin
      fcfd_d = 1'b0;
    end
    ll6_d   = ll6_q;
    if (len_q < hsc_pkg::LenLinkLocal && ch != hsc_pkg::linklocal_char(len_q)) begin
      ll6_d = 1'b0;
    end
    colon_d = colon_q || (ch == hsc_pkg::ChColon);

    oct_d      = oct_q;
    idx_d      = idx_q;
    nonempty_d = nonempty_q;
    failed_d   = failed_q;
    addr_d     = addr_q;
    if (is_digit) begin
      oct_d      = (oct_acc > 13'd256) ? hsc_pkg::OctetSat : oct_acc[hsc_pkg::OctetW-1:0];
      nonempty_d = 1'b1;
    end else if (ch == hsc_pkg::ChDot) begin
      if (!nonempty_q || oct_q > hsc_pkg::OctetMax || idx_q == 2'd3) begin
        failed_d = 1'b1;
      end else begin
        addr_d = {addr_q[23:0], oct_q[7:0]};
        idx_d  = idx_q + 2'd1;
      end
      oct_d      = '0;
      nonempty_d = 1'b0;
    end else begin
      failed_d = 1'b1;
    end

    // verdict from the state after this character
    v4_ok     = !failed_d && idx_d == 2'd3 && nonempty_d && oct_d <= hsc_pkg::OctetMax;
    addr_full = v4_ok ? {addr_d[23:0], oct_d[7:0]} : '0;
    oa        = addr_full[31:24];
    ob        = addr_full[23:16];

    cls = hsc_pkg::CLS_NONE;
    if (lh_d && len_d == hsc_pkg::LenLocalhost) begin
      cls = hsc_pkg::CLS_LOCALHOST;
    end else if (v4_ok) begin
      if (oa == hsc_pkg::Oct10 || oa == hsc_pkg::Oct127 ||
          (oa == hsc_pkg::Oct169 && ob == hsc_pkg::Oct254) ||
          (oa == hsc_pkg::Oct172 && ob >= hsc_pkg::Oct16 && ob <= hsc_pkg::Oct31) ||
          (oa == hsc_pkg::Oct192 && ob == hsc_pkg::Oct168)) begin
        cls = hsc_pkg::CLS_PRIV4;
      end
    end else if (colon_d) begin
      if (lp6_d && len_d == hsc_pkg::LenLoop6) begin
        cls = hsc_pkg::CLS_LOOP6;
      end else if ((fcfd_d && len_d >= hsc_pkg::LenFcfd) ||
                   (ll6_d && len_d >= hsc_pkg::LenLinkLocal)) begin
        cls = hsc_pkg::CLS_LOCAL6;
      end
    end

    verdict_o.is_local     = (cls != hsc_pkg::CLS_NONE);
    verdict_o.host_class   = cls;
    verdict_o.ipv4_valid   = v4_ok;
    verdict_o.ipv4_address = addr_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      lh_q       <= 1'b1;
      lp6_q      <= 1'b1;
      fcfd_q     <= 1'b1;
      ll6_q      <= 1'b1;
      colon_q    <= 1'b0;
      oct_q      <= '0;
      idx_q      <= '0;
      nonempty_q <= 1'b0;
      failed_q   <= 1'b0;
      addr_q     <= '0;
    end else if (take_i) begin
      if (last_i) begin
        len_q      <= '0;
        lh_q       <= 1'b1;
        lp6_q      <= 1'b1;
        fcfd_q     <= 1'b1;
        ll6_q      <= 1'b1;
        colon_q    <= 1'b0;
        oct_q      <= '0;
        idx_q      <= '0;
        nonempty_q <= 1'b0;
        failed_q   <= 1'b0;
        addr_q     <= '0;
      end else begin
        len_q      <= len_d;
        lh_q       <= lh_d;
        lp6_q      <= lp6_d;
        fcfd_q     <= fcfd_d;
        ll6_q      <= ll6_d;
        colon_q    <= colon_d;
        oct_q      <= oct_d;
        idx_q      <= idx_d;
        nonempty_q <= nonempty_d;
        failed_q   <= failed_d;
        addr_q     <= addr_d;
      end
    end
  end

endmodule

[design/host_scope_classifier.sv]
// ----------------------------------------------------------------------------
// host_scope_classifier: local-scope verdict for a streamed host name
// Input register, per-character parser, and an output register.
// ----------------------------------------------------------------------------
// The output register captures the verdict when the parser takes the final item.
// Throughput: one item per cycle; the output register frees the input side
// while a verdict waits, so only a held verdict plus a pending final item stalls.
// Reset: asynchronous, active low; clears valid flags and the parser state.
module host_scope_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [hsc_pkg::CharW-1:0]   char_code_i,
  input  logic                        last_char_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        is_local_o,
  output logic [2:0]                  host_class_o,
  output logic                        ipv4_valid_o,
  output logic [hsc_pkg::AddrW-1:0]   ipv4_address_o
);

  logic                       in_vld_q;
  logic [hsc_pkg::CharW-1:0]  in_char_q;
  logic                       in_last_q;
  logic                       out_vld_q;
  hsc_pkg::verdict_t          out_q;
  hsc_pkg::verdict_t          verdict;
  logic                       out_free;
  logic                       take;

  assign out_free   = !out_vld_q || !out_stall_i;
  // a non-final item never needs the output slot
  assign take       = in_vld_q && (!in_last_q || out_free);
  assign in_stall_o = in_vld_q && !take;

  hsc_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .char_i    (in_char_q),
    .last_i    (in_last_q),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (take && in_last_q) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_char_q <= char_code_i;
      in_last_q <= last_char_i;
    end
    if (take && in_last_q) begin
      out_q <= verdict;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign is_local_o     = out_q.is_local;
  assign host_class_o   = out_q.host_class;
  assign ipv4_valid_o   = out_q.ipv4_valid;
  assign ipv4_address_o = out_q.ipv4_address;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_last_q && out_vld_q && out_stall_i))
    else $error("input stalled without a held verdict");

  a_local_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (is_local_o == (out_q.host_class != hsc_pkg::CLS_NONE)))
    else $error("is_local disagrees with host_class");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !ipv4_valid_o) |-> (ipv4_address_o == '0))
    else $error("address nonzero for invalid ipv4");

  a_priv4_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.host_class == hsc_pkg::CLS_PRIV4) |-> ipv4_valid_o)
    else $error("private ipv4 class without a valid address");

endmodule
